// ===== rtl/core/bba_pkg.sv =====
// Package for the bitmap block allocator: field widths, command and status
// codes, controller states and the command/status structs between the modules.
// No dependencies.
package bba_pkg;

   localparam int BLOCK_COUNT_DEFAULT = 1024;

   localparam int CMD_W   = 2;
   localparam int BLOCK_W = 10;

   // Summary chunk: words whose non-empty flags are encoded together.
   localparam int CHUNK_W  = 32;
   localparam int CHUNK_AW = 5;

   localparam logic [7:0] FULL_WORD = 8'hff;

   localparam logic [CMD_W-1:0] CMD_ALLOCATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESERVE  = 2'd2;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MODIFY
   } state_type;

   typedef struct packed {
      logic clear;   // write one reset word, advance sweep
      logic accept;  // latch the incoming transaction
      logic read;    // resolve word address, read map word
      logic modify;  // write back word, load response
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;  // sweep sits on the last map word
      logic rsp_busy;    // response register full and not taken
   } dp_status_type;

   // Position of the lowest set bit; 7 for an all-zero word.
   function automatic logic [2:0] lowest_set_bit(input logic [7:0] word);
      logic [2:0] pos;
      pos = 3'd7;
      for (int i = 7; i >= 0; i--) begin
         if (word[i]) begin
            pos = 3'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ===== rtl/core/bba_req_if.sv =====
// Command channel of the bitmap block allocator: valid/ready plus payload.
// Depends on bba_pkg.
interface bba_req_if;
   import bba_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [BLOCK_W-1:0] block_number;

   modport source (output valid, output cmd, output block_number, input ready);
   modport sink   (input valid, input cmd, input block_number, output ready);
endinterface

// ===== rtl/core/bba_rsp_if.sv =====
// Response channel of the bitmap block allocator: valid/ready plus payload.
// Depends on bba_pkg.
interface bba_rsp_if;
   import bba_pkg::*;

   logic               valid;
   logic               ready;
   logic [BLOCK_W-1:0] granted_block;
   logic               status;

   modport source (output valid, output granted_block, output status, input ready);
   modport sink   (input valid, input granted_block, input status, output ready);
endinterface

// ===== rtl/core/bba_ctrl.sv =====
// Controller of the bitmap block allocator: clearing sweep, accept, read, modify.
// Depends on bba_pkg.
module bba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bba_pkg::dp_status_type dp_status,
   output bba_pkg::ctrl_cmd_type  ctl_cmd
);
   import bba_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      ctl_cmd   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl_cmd.clear = 1'b1;
            if (dp_status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl_cmd.accept = 1'b1;
               state_in       = ST_READ;
            end
         end
         ST_READ: begin
            ctl_cmd.read = 1'b1;
            state_in     = ST_MODIFY;
         end
         ST_MODIFY: begin
            // hold until the response register can take the result
            if (!dp_status.rsp_busy) begin
               ctl_cmd.modify = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// ===== rtl/core/bba_datapath.sv =====
// Datapath of the bitmap block allocator: free map memory, summary flags,
// first-free search, read-modify-write and response register.
// Depends on bba_pkg and bba_rsp_if.
module bba_datapath #(
   parameter int BLOCK_COUNT = bba_pkg::BLOCK_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bba_pkg::ctrl_cmd_type         ctl_cmd,
   output bba_pkg::dp_status_type        dp_status,
   input  logic [bba_pkg::CMD_W-1:0]     req_cmd,
   input  logic [bba_pkg::BLOCK_W-1:0]   req_block_number,
   bba_rsp_if.source                     rsp
);
   import bba_pkg::*;

   localparam int MAP_WORDS  = (BLOCK_COUNT + 7) / 8;
   localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int NUM_CHUNKS = (MAP_WORDS + CHUNK_W - 1) / CHUNK_W;
   localparam int CHK_AW     = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int SUM_W      = NUM_CHUNKS * CHUNK_W;
   localparam int TAIL_BITS  = BLOCK_COUNT % 8;
   localparam logic [7:0] LAST_WORD_INIT =
      (TAIL_BITS == 0) ? FULL_WORD : 8'((1 << TAIL_BITS) - 1);
   localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);

   logic [7:0] map_mem [MAP_WORDS];

   logic [CMD_W-1:0]    item_cmd_ff,  item_cmd_in;
   logic [BLOCK_W-1:0]  item_blk_ff,  item_blk_in;
   logic [WORD_AW-1:0]  addr_ff,      addr_in;
   logic                hit_ff,       hit_in;
   logic [7:0]          rd_data_ff;
   logic [WORD_AW-1:0]  clear_cnt_ff, clear_cnt_in;
   logic [MAP_WORDS-1:0] sum_ff,      sum_in;
   logic [NUM_CHUNKS-1:0] chunk_any_ff, chunk_any_in;
   logic [CHUNK_AW-1:0] chunk_idx_ff [NUM_CHUNKS];
   logic [CHUNK_AW-1:0] chunk_idx_in [NUM_CHUNKS];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]  rsp_granted_ff, rsp_granted_in;
   logic                rsp_status_ff,  rsp_status_in;

   logic [SUM_W-1:0]    sum_pad;
   logic [CHK_AW-1:0]   chunk_sel;
   logic                any_free;
   logic [31:0]         word_wide;
   logic [31:0]         blk_wide;
   logic [31:0]         grant_wide;
   logic                blk_ok;
   logic [2:0]          low_bit;
   logic [7:0]          blk_mask;
   logic [7:0]          new_word;
   logic                do_write;
   logic                wr_en;
   logic [WORD_AW-1:0]  wr_addr;
   logic [7:0]          wr_data;

   // First level of the search: encode each chunk of summary flags.
   always_comb begin
      sum_pad = SUM_W'(sum_ff);
      for (int c = 0; c < NUM_CHUNKS; c++) begin
         chunk_any_in[c] = |sum_pad[c*CHUNK_W +: CHUNK_W];
         chunk_idx_in[c] = '0;
         for (int i = CHUNK_W - 1; i >= 0; i--) begin
            if (sum_pad[c*CHUNK_W + i]) begin
               chunk_idx_in[c] = CHUNK_AW'(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      chunk_any_ff <= chunk_any_in;
      chunk_idx_ff <= chunk_idx_in;
   end

   // Second level: lowest non-empty chunk gives the first free word.
   always_comb begin
      chunk_sel = '0;
      for (int c = NUM_CHUNKS - 1; c >= 0; c--) begin
         if (chunk_any_ff[c]) begin
            chunk_sel = CHK_AW'(c);
         end
      end
      any_free  = |chunk_any_ff;
      word_wide = (32'(chunk_sel) << CHUNK_AW) | 32'(chunk_idx_ff[chunk_sel]);
   end

   always_comb begin
      item_cmd_in = ctl_cmd.accept ? req_cmd : item_cmd_ff;
      item_blk_in = ctl_cmd.accept ? req_block_number : item_blk_ff;

      blk_wide = 32'(item_blk_ff) >> 3;
      blk_ok   = 32'(item_blk_ff) < 32'(BLOCK_COUNT);

      addr_in = addr_ff;
      hit_in  = hit_ff;
      if (ctl_cmd.read) begin
         case (item_cmd_ff)
            CMD_ALLOCATE: begin
               addr_in = word_wide[WORD_AW-1:0];
               hit_in  = any_free;
            end
            CMD_FREE, CMD_RESERVE: begin
               addr_in = blk_wide[WORD_AW-1:0];
               hit_in  = blk_ok;
            end
            default: begin
               addr_in = blk_wide[WORD_AW-1:0];
               hit_in  = 1'b0;
            end
         endcase
      end

      clear_cnt_in = ctl_cmd.clear ? clear_cnt_ff + 1'b1 : clear_cnt_ff;
   end

   // Read-modify-write of one map word.
   always_comb begin
      low_bit    = lowest_set_bit(rd_data_ff);
      blk_mask   = 8'd1 << item_blk_ff[2:0];
      grant_wide = (32'(addr_ff) << 3) | 32'(low_bit);
      new_word   = rd_data_ff;
      do_write   = 1'b0;
      rsp_granted_in = '0;
      rsp_status_in  = STATUS_DONE;
      case (item_cmd_ff)
         CMD_ALLOCATE: begin
            if (hit_ff) begin
               new_word       = rd_data_ff & ~(8'd1 << low_bit);
               do_write       = 1'b1;
               rsp_granted_in = grant_wide[BLOCK_W-1:0];
            end else begin
               rsp_status_in = STATUS_FULL;
            end
         end
         CMD_FREE: begin
            new_word = rd_data_ff | blk_mask;
            do_write = hit_ff;
         end
         CMD_RESERVE: begin
            new_word = rd_data_ff & ~blk_mask;
            do_write = hit_ff;
         end
         default: begin
            do_write = 1'b0;
         end
      endcase

      sum_in = sum_ff;
      if (ctl_cmd.modify && do_write) begin
         sum_in[addr_ff] = |new_word;
      end

      wr_en   = ctl_cmd.clear || (ctl_cmd.modify && do_write);
      wr_addr = ctl_cmd.clear ? clear_cnt_ff : addr_ff;
      if (ctl_cmd.clear) begin
         wr_data = (clear_cnt_ff == LAST_WORD) ? LAST_WORD_INIT : FULL_WORD;
      end else begin
         wr_data = new_word;
      end

      if (ctl_cmd.modify) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (ctl_cmd.read) begin
         rd_data_ff <= map_mem[addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         sum_ff       <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_cmd_ff <= item_cmd_in;
      item_blk_ff <= item_blk_in;
      addr_ff     <= addr_in;
      hit_ff      <= hit_in;
      if (ctl_cmd.modify) begin
         rsp_granted_ff <= rsp_granted_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.granted_block = rsp_granted_ff;
   assign rsp.status        = rsp_status_ff;

   assign dp_status.clear_last = (clear_cnt_ff == LAST_WORD);
   assign dp_status.rsp_busy   = rsp_valid_ff && !rsp.ready;

endmodule

// ===== rtl/core/bitmap_block_allocator_top.sv =====
// Bitmap free-block allocator, first fit: one response per command transaction.
// Takes the request and response interfaces; depends on bba_pkg, bba_ctrl and
// bba_datapath.
//
// The block holds a free map of BLOCK_COUNT blocks, one bit per block (1 = free),
// in a memory of 8-bit words; block n is bit n%8 of word n/8. Allocate returns the
// lowest free block and marks it used, or status 1 with block 0 when the map is
// full. Free and reserve set or clear the given bit; a block number at or beyond
// BLOCK_COUNT, and command code 3, leave the map alone and answer status 0,
// block 0. Each transaction goes through accept, map word read (the
// registered memory read port) and read-modify-write with the response loaded
// into the output register; the next command is accepted while that response
// waits, and the write-back holds only while an earlier response is still not
// taken. The first free word comes from a per-word non-empty flag vector, encoded
// in registered chunks of 32 flags and then across chunks. After reset a clearing
// pass writes every map word once, one word per cycle; no command is accepted
// until it is done. Granted block numbers above 1023 are reported in their low
// 10 bits.
module bitmap_block_allocator_top #(
   parameter int BLOCK_COUNT = bba_pkg::BLOCK_COUNT_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   bba_req_if.sink   req_chan,
   bba_rsp_if.source rsp_chan
);
   import bba_pkg::*;

   ctrl_cmd_type  ctl_cmd;
   dp_status_type dp_status;

   // Sequence the sweep and each transaction.
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .dp_status (dp_status),
      .ctl_cmd   (ctl_cmd)
   );

   // Hold the map, search it and build the response.
   bba_datapath #(
      .BLOCK_COUNT (BLOCK_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl_cmd          (ctl_cmd),
      .dp_status        (dp_status),
      .req_cmd          (req_chan.cmd),
      .req_block_number (req_chan.block_number),
      .rsp              (rsp_chan)
   );

   // An accepted transaction goes straight to the map read.
   a_accept_then_read: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> ctl_cmd.read)
      else $error("accepted transaction did not proceed to the map read");

   // Never overwrite a response that is still waiting.
   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.modify |-> !(rsp_chan.valid && !rsp_chan.ready))
      else $error("response register loaded while holding an untaken response");

   // A failed allocate reports block zero.
   a_full_grants_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == STATUS_FULL)) |->
         (rsp_chan.granted_block == '0))
      else $error("full status with a non-zero granted block");

   // No new command while the sweep runs or a transaction reads the map.
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      (ctl_cmd.clear || ctl_cmd.read) |-> !req_chan.ready)
      else $error("request ready while the map is busy");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for bitmap_block_allocator_top: drives allocate, free,
// reserve and unused-code transactions, predicts each response from a private free map.
// Depends on bba_pkg, bba_req_if, bba_rsp_if and the allocator RTL.
module testbench;
   import bba_pkg::*;

   localparam int MAP_BLOCKS = BLOCK_COUNT_DEFAULT;
   localparam int MAP_WORDS  = (MAP_BLOCKS + 7) / 8;
   localparam int IDLE_PCT   = 16;
   // Responses seen before the receiver holds off, and how long it holds.
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 250;
   // Transaction window in which neither side idles.
   localparam int BUSY_FROM = 400;
   localparam int BUSY_TO   = 700;
   localparam int DRAIN_CYCLES = 20;

   // Command code with no defined operation.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [BLOCK_W-1:0] block_number;
      bit                 drain_first;  // wait for every response before offering
   } command_item_type;

   typedef struct {
      logic [BLOCK_W-1:0] granted_block;
      logic               status;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Tenth-of-a-period delays are not needed: drive at negedge, sample at posedge.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bba_req_if req_if ();
   bba_rsp_if rsp_if ();

   // Driven copies of the block inputs, known from time zero.
   logic               drv_valid = 1'b0;
   logic [CMD_W-1:0]   drv_cmd   = CMD_ALLOCATE;
   logic [BLOCK_W-1:0] drv_block = '0;
   logic               drv_ready = 1'b0;

   assign req_if.valid        = drv_valid;
   assign req_if.cmd          = drv_cmd;
   assign req_if.block_number = drv_block;
   assign rsp_if.ready        = drv_ready;

   bitmap_block_allocator_top #(
      .BLOCK_COUNT (MAP_BLOCKS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   command_item_type pending_commands [$];
   alloc_result_type expected_results [$];
   logic [7:0]       free_map_model [MAP_WORDS];

   int  accepted_count = 0;
   int  result_count   = 0;
   int  error_count    = 0;
   bit  req_taken      = 1'b0;
   int  hold_left      = 0;
   bit  hold_done      = 1'b0;

   alloc_result_type want;

   // Apply one command to the model free map and return the response it owes.
   function automatic alloc_result_type apply_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [BLOCK_W-1:0] blk);
      alloc_result_type res;
      bit               found;
      int               bit_pos;
      res.granted_block = '0;
      res.status        = STATUS_DONE;
      found             = 1'b0;
      case (cmd)
         CMD_ALLOCATE: begin
            // First non-empty word, then its lowest set bit.
            for (int w = 0; w < MAP_WORDS; w++) begin
               if (!found && free_map_model[w] != 8'h00) begin
                  bit_pos = 0;
                  while (!free_map_model[w][bit_pos]) begin
                     bit_pos++;
                  end
                  free_map_model[w][bit_pos] = 1'b0;
                  res.granted_block = BLOCK_W'(w * 8 + bit_pos);
                  found = 1'b1;
               end
            end
            if (!found) begin
               res.status = STATUS_FULL;
            end
         end
         CMD_FREE: begin
            if (int'(blk) < MAP_BLOCKS) begin
               free_map_model[blk >> 3][blk[2:0]] = 1'b1;
            end
         end
         CMD_RESERVE: begin
            if (int'(blk) < MAP_BLOCKS) begin
               free_map_model[blk >> 3][blk[2:0]] = 1'b0;
            end
         end
         default: begin
            // Unused code: map untouched, plain done response.
         end
      endcase
      return res;
   endfunction

   function automatic void add_command(input logic [CMD_W-1:0] cmd,
                                       input logic [BLOCK_W-1:0] blk,
                                       input bit drain_first = 1'b0);
      command_item_type item;
      item.cmd          = cmd;
      item.block_number = blk;
      item.drain_first  = drain_first;
      pending_commands.push_back(item);
   endfunction

   // Half the time stay in the low blocks, where allocations land.
   function automatic logic [BLOCK_W-1:0] pick_block();
      if ($urandom_range(1) == 0) begin
         return BLOCK_W'($urandom_range(63));
      end
      return BLOCK_W'($urandom_range(MAP_BLOCKS - 1));
   endfunction

   // Sample accepted commands at the rising edge and predict their responses.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         for (int n = 0; n < MAP_WORDS * 8; n++) begin
            free_map_model[n >> 3][n & 7] = (n < MAP_BLOCKS);
         end
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            void'(pending_commands.pop_front());
            expected_results.push_back(apply_command(req_if.cmd, req_if.block_number));
            accepted_count++;
         end
      end
   end

   // Offer the next command at the falling edge; hold a command until taken.
   always @(negedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else if (!(drv_valid && !req_taken)) begin
         if (pending_commands.size() == 0
             || (pending_commands[0].drain_first && expected_results.size() != 0)
             || (!(accepted_count >= BUSY_FROM && accepted_count < BUSY_TO)
                 && $urandom_range(99) < IDLE_PCT)) begin
            drv_valid <= 1'b0;
         end else begin
            drv_valid <= 1'b1;
            drv_cmd   <= pending_commands[0].cmd;
            drv_block <= pending_commands[0].block_number;
         end
      end
   end

   // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && result_count >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // Drop ready at random outside the busy window; hold it low during the hold-off.
   always @(negedge clock) begin
      if (reset || hold_left != 0) begin
         drv_ready <= 1'b0;
      end else if (result_count >= BUSY_FROM && result_count < BUSY_TO) begin
         drv_ready <= 1'b1;
      end else begin
         drv_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Check each response transaction against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         result_count++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual block %0d status %0d",
                     $time, rsp_if.granted_block, rsp_if.status);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.granted_block !== want.granted_block) begin
               $display("%0t: granted_block mismatch, expected %0d, actual %0d",
                        $time, want.granted_block, rsp_if.granted_block);
               error_count++;
            end
            if (rsp_if.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_if.status);
               error_count++;
            end
         end
      end
   end

   // Build the whole stimulus, release reset, then wait for the last response.
   initial begin
      int pick;

      // Directed: first grants, free/reserve at both ends of the map,
      // no-op free and reserve, unused command, ignored block on allocate.
      add_command(CMD_ALLOCATE, 10'd0);
      add_command(CMD_ALLOCATE, 10'd0);
      add_command(CMD_RESERVE,  10'd2);
      add_command(CMD_ALLOCATE, 10'd0);
      add_command(CMD_FREE,     10'd0);
      add_command(CMD_ALLOCATE, 10'd0);
      add_command(CMD_FREE,     10'd1023);
      add_command(CMD_RESERVE,  10'd1023);
      add_command(CMD_RESERVE,  10'd1023);
      add_command(CMD_FREE,     10'd1023);
      add_command(CMD_UNUSED,   10'd1023);
      add_command(CMD_UNUSED,   10'd0);
      add_command(CMD_FREE,     10'd5);
      add_command(CMD_RESERVE,  10'd8);
      add_command(CMD_RESERVE,  10'd512);
      add_command(CMD_ALLOCATE, 10'd1023);
      add_command(CMD_FREE,     10'd3);
      add_command(CMD_FREE,     10'd1);
      add_command(CMD_ALLOCATE, 10'd0);
      add_command(CMD_ALLOCATE, 10'd0);
      add_command(CMD_FREE,     10'd512);

      // Mixed traffic on a partly used map.
      repeat (100) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            add_command(CMD_ALLOCATE, BLOCK_W'($urandom_range(MAP_BLOCKS - 1)));
         end else if (pick < 70) begin
            add_command(CMD_FREE, pick_block());
         end else if (pick < 90) begin
            add_command(CMD_RESERVE, pick_block());
         end else begin
            add_command(CMD_UNUSED, pick_block());
         end
      end

      // Pause until the map settles, then allocate past the last free block.
      add_command(CMD_ALLOCATE, BLOCK_W'($urandom_range(MAP_BLOCKS - 1)), 1'b1);
      repeat (MAP_BLOCKS + 6) begin
         add_command(CMD_ALLOCATE, BLOCK_W'($urandom_range(MAP_BLOCKS - 1)));
      end

      // Near full: scattered frees race allocations that often hit a full map.
      repeat (50) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            add_command(CMD_FREE, BLOCK_W'($urandom_range(MAP_BLOCKS - 1)));
         end else if (pick < 80) begin
            add_command(CMD_ALLOCATE, BLOCK_W'($urandom_range(MAP_BLOCKS - 1)));
         end else if (pick < 95) begin
            add_command(CMD_RESERVE, BLOCK_W'($urandom_range(MAP_BLOCKS - 1)));
         end else begin
            add_command(CMD_UNUSED, BLOCK_W'($urandom_range(MAP_BLOCKS - 1)));
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_commands.size() != 0 || drv_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      // Let any stray response show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/bba_pkg.sv
rtl/core/bba_req_if.sv
rtl/core/bba_rsp_if.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_datapath.sv
rtl/core/bitmap_block_allocator_top.sv
bench/testbench.sv
